// ----- rtl/core/bphdc_pkg.sv -----
// Shared types, codes and reset values for the button press/hold/double classifier.
`timescale 1ns / 1ps

package bphdc_pkg;

   localparam int TIME_BITS = 32;
   localparam int NOW_BITS  = 32;
   localparam int HOLD_BITS = 32;
   localparam int MS_BITS   = 16;

   localparam int REQ_BITS  = 1 + NOW_BITS;
   localparam int REQ_BYTES = (REQ_BITS + 7) / 8;
   localparam int RSP_BITS  = 3 + 2 + HOLD_BITS;
   localparam int RSP_BYTES = (RSP_BITS + 7) / 8;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [MS_BITS-1:0]   ms_type;

   typedef enum logic [2:0] {
      ST_UNPRESSED = 3'd0,
      ST_DEBOUNCE  = 3'd1,
      ST_PRESSED   = 3'd2,
      ST_DOUBLE    = 3'd3,
      ST_STILL     = 3'd4,
      ST_HELD      = 3'd5,
      ST_RELEASED  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_PRESS  = 2'd1,
      KIND_DOUBLE = 2'd2,
      KIND_HOLD   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_ACTIVE_HIGH   = 3'd0,
      REG_PRESS_DEB     = 3'd1,
      REG_RELEASE_DEB   = 3'd2,
      REG_HOLD_THRESH   = 3'd3,
      REG_DOUBLE_WINDOW = 3'd4
   } reg_index_type;

   localparam ms_type PRESS_DEB_RESET     = 16'd50;
   localparam ms_type RELEASE_DEB_RESET   = 16'd50;
   localparam ms_type HOLD_THRESH_RESET   = 16'd1000;
   localparam ms_type DOUBLE_WINDOW_RESET = 16'd300;

endpackage

// ----- rtl/core/button_press_hold_double_classifier.sv -----
// Top level of the button press/hold/double classifier: input register, classifier, result register.
//
//  channel | dir | transfer when           | payload
//  req     | in  | req_tvalid & req_tready | tdata: pin_level, now_ms
//  rsp     | out | rsp_tvalid & rsp_tready | tdata: scan_status, released_kind, hold_duration_ms
//  csr     | in  | psel & penable & pwrite | five registers at byte address 4*i
//
// One scan per cycle while the result side is not stalled; a scan passes the input register
// and then the result register before rsp_tvalid rises.
// The classifier is combinational between the input register and the result register.
// A stalled result register holds both stages; the input side keeps taking scans
// while the input register is free. Synchronous reset clears state and valid flags.
`timescale 1ns / 1ps

module button_press_hold_double_classifier (
   input  logic clock,
   input  logic reset,

   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [0] pin_level, [32:1] now_ms, rest zero
   input  logic [bphdc_pkg::REQ_BYTES*8-1:0]     req_tdata,

   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [2:0] scan_status, [4:3] released_kind, [36:5] hold_duration_ms, rest zero
   output logic [bphdc_pkg::RSP_BYTES*8-1:0]     rsp_tdata,

   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [bphdc_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [bphdc_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [bphdc_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   import bphdc_pkg::*;

   // configuration
   logic   active_high_ff;
   ms_type press_deb_ff;
   ms_type release_deb_ff;
   ms_type hold_thresh_ff;
   ms_type double_window_ff;

   reg_index_type csr_index;
   ms_type        csr_v16;
   logic          csr_write;

   // input register
   logic          in_valid_ff;
   logic          in_level_ff;
   time_type      in_now_ff;

   // classifier state
   logic          was_touched_ff,   was_touched_in;
   status_type    last_class_ff,    last_class_in;
   time_type      press_stamp_ff,   press_stamp_in;
   time_type      release_stamp_ff, release_stamp_in;

   // result register
   logic                  out_valid_ff;
   status_type            out_status_ff,  out_status_in;
   kind_type              out_kind_ff,    out_kind_in;
   logic [HOLD_BITS-1:0]  out_hold_ff,    out_hold_in;

   logic     advance;
   logic     touched;
   time_type since_press;
   time_type since_release;
   time_type since_new_press;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign csr_v16    = csr_pwdata[MS_BITS-1:0];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_high_ff   <= 1'b0;
         press_deb_ff     <= PRESS_DEB_RESET;
         release_deb_ff   <= RELEASE_DEB_RESET;
         hold_thresh_ff   <= HOLD_THRESH_RESET;
         double_window_ff <= DOUBLE_WINDOW_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ACTIVE_HIGH: begin
               active_high_ff <= csr_pwdata[0];
            end
            REG_PRESS_DEB: begin
               press_deb_ff <= (csr_v16 > hold_thresh_ff) ? hold_thresh_ff : csr_v16;
            end
            REG_RELEASE_DEB: begin
               release_deb_ff <= (csr_v16 > double_window_ff) ? double_window_ff : csr_v16;
            end
            REG_HOLD_THRESH: begin
               hold_thresh_ff <= (csr_v16 < press_deb_ff) ? press_deb_ff : csr_v16;
            end
            REG_DOUBLE_WINDOW: begin
               double_window_ff <= (csr_v16 < release_deb_ff) ? release_deb_ff : csr_v16;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_ACTIVE_HIGH:   csr_prdata = CSR_DATA_BITS'(active_high_ff);
         REG_PRESS_DEB:     csr_prdata = CSR_DATA_BITS'(press_deb_ff);
         REG_RELEASE_DEB:   csr_prdata = CSR_DATA_BITS'(release_deb_ff);
         REG_HOLD_THRESH:   csr_prdata = CSR_DATA_BITS'(hold_thresh_ff);
         REG_DOUBLE_WINDOW: csr_prdata = CSR_DATA_BITS'(double_window_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // flow control
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_level_ff <= req_tdata[0];
         in_now_ff   <= TIME_BITS'(req_tdata[NOW_BITS:1]);
      end
   end

   // classify
   assign touched         = active_high_ff ? in_level_ff : !in_level_ff;
   assign since_press     = in_now_ff - press_stamp_ff;
   assign since_release   = in_now_ff - release_stamp_ff;
   assign since_new_press = in_now_ff - press_stamp_in;

   always_comb begin
      was_touched_in   = was_touched_ff;
      last_class_in    = last_class_ff;
      press_stamp_in   = press_stamp_ff;
      release_stamp_in = release_stamp_ff;
      out_kind_in      = KIND_NONE;
      out_status_in    = ST_UNPRESSED;
      if (since_press < TIME_BITS'(press_deb_ff) ||
          since_release < TIME_BITS'(release_deb_ff)) begin
         out_status_in = ST_DEBOUNCE;
      end else begin
         was_touched_in = touched;
         if (touched) begin
            if (was_touched_ff) begin
               if (since_press < TIME_BITS'(hold_thresh_ff)) begin
                  out_status_in = ST_STILL;
               end else begin
                  out_status_in = ST_HELD;
                  last_class_in = ST_HELD;
               end
            end else begin
               press_stamp_in = in_now_ff;
               out_status_in  = (since_release < TIME_BITS'(double_window_ff)) ?
                                ST_DOUBLE : ST_PRESSED;
               last_class_in  = out_status_in;
            end
         end else if (was_touched_ff) begin
            release_stamp_in = in_now_ff;
            case (last_class_ff)
               ST_PRESSED: out_kind_in = KIND_PRESS;
               ST_DOUBLE:  out_kind_in = KIND_DOUBLE;
               ST_HELD:    out_kind_in = KIND_HOLD;
               default:    out_kind_in = KIND_NONE;
            endcase
            last_class_in = ST_RELEASED;
            out_status_in = ST_RELEASED;
         end
      end
      out_hold_in = (last_class_in == ST_HELD) ? HOLD_BITS'(since_new_press) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         was_touched_ff   <= 1'b0;
         last_class_ff    <= ST_UNPRESSED;
         press_stamp_ff   <= '0;
         release_stamp_ff <= '0;
         out_valid_ff     <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            was_touched_ff   <= was_touched_in;
            last_class_ff    <= last_class_in;
            press_stamp_ff   <= press_stamp_in;
            release_stamp_ff <= release_stamp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_status_ff <= out_status_in;
         out_kind_ff   <= out_kind_in;
         out_hold_ff   <= out_hold_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_BYTES*8-RSP_BITS){1'b0}}, out_hold_ff, out_kind_ff, out_status_ff};

endmodule

// ----- test/button_scan_checker.sv -----
// Checker for the button classifier: follows register transfers, predicts every scan result, compares.
`timescale 1ns / 1ps

module button_scan_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic [bphdc_pkg::REQ_BYTES*8-1:0]     req_tdata,
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [bphdc_pkg::RSP_BYTES*8-1:0]     rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [bphdc_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [bphdc_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   input  logic [bphdc_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   input  logic                                  csr_pready,
   output int                                    mismatch_count,
   output int                                    results_waiting
);

   import bphdc_pkg::*;

   typedef struct {
      status_type           status;
      kind_type             kind;
      logic [HOLD_BITS-1:0] hold_ms;
   } scan_result_type;

   logic       active_high;
   ms_type     press_deb;
   ms_type     release_deb;
   ms_type     hold_thresh;
   ms_type     double_window;

   logic       was_touched;
   status_type last_class;
   time_type   press_stamp;
   time_type   release_stamp;

   scan_result_type expected_results[$];

   function automatic scan_result_type classify_scan(input logic pin, input time_type now_ms);
      scan_result_type r;
      time_type        since_press;
      time_type        since_release;
      logic            touched;
      logic            prior;
      since_press = now_ms - press_stamp;
      since_release = now_ms - release_stamp;
      touched = active_high ? pin : !pin;
      r.status = ST_UNPRESSED;
      r.kind = KIND_NONE;
      r.hold_ms = '0;
      if (since_press < press_deb || since_release < release_deb) begin
         r.status = ST_DEBOUNCE;
      end else begin
         prior = was_touched;
         was_touched = touched;
         if (touched && prior) begin
            if (since_press < hold_thresh) begin
               r.status = ST_STILL;
            end else begin
               r.status = ST_HELD;
               last_class = ST_HELD;
            end
         end else if (touched) begin
            press_stamp = now_ms;
            if (since_release < double_window) begin
               r.status = ST_DOUBLE;
            end else begin
               r.status = ST_PRESSED;
            end
            last_class = r.status;
         end else if (prior) begin
            release_stamp = now_ms;
            case (last_class)
               ST_PRESSED: r.kind = KIND_PRESS;
               ST_DOUBLE:  r.kind = KIND_DOUBLE;
               ST_HELD:    r.kind = KIND_HOLD;
               default:    r.kind = KIND_NONE;
            endcase
            last_class = ST_RELEASED;
            r.status = ST_RELEASED;
         end
      end
      if (last_class == ST_HELD) begin
         r.hold_ms = now_ms - press_stamp;
      end
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      scan_result_type            want;
      logic [CSR_DATA_BITS-1:0]   held_value;
      ms_type                     written;
      logic [2:0]                 got_status;
      logic [1:0]                 got_kind;
      logic [HOLD_BITS-1:0]       got_hold;
      if (reset) begin
         active_high = 1'b0;
         press_deb = PRESS_DEB_RESET;
         release_deb = RELEASE_DEB_RESET;
         hold_thresh = HOLD_THRESH_RESET;
         double_window = DOUBLE_WINDOW_RESET;
         was_touched = 1'b0;
         last_class = ST_UNPRESSED;
         press_stamp = '0;
         release_stamp = '0;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            written = csr_pwdata[MS_BITS-1:0];
            if (csr_pwrite) begin
               case (csr_paddr[CSR_ADDR_BITS-1:2])
                  REG_ACTIVE_HIGH:   active_high = csr_pwdata[0];
                  REG_PRESS_DEB:     press_deb = (written > hold_thresh) ? hold_thresh : written;
                  REG_RELEASE_DEB:   release_deb = (written > double_window) ? double_window
                                                                            : written;
                  REG_HOLD_THRESH:   hold_thresh = (written < press_deb) ? press_deb : written;
                  REG_DOUBLE_WINDOW: double_window = (written < release_deb) ? release_deb
                                                                              : written;
                  default: ;
               endcase
            end else begin
               held_value = '0;
               case (csr_paddr[CSR_ADDR_BITS-1:2])
                  REG_ACTIVE_HIGH:   held_value[0] = active_high;
                  REG_PRESS_DEB:     held_value[MS_BITS-1:0] = press_deb;
                  REG_RELEASE_DEB:   held_value[MS_BITS-1:0] = release_deb;
                  REG_HOLD_THRESH:   held_value[MS_BITS-1:0] = hold_thresh;
                  REG_DOUBLE_WINDOW: held_value[MS_BITS-1:0] = double_window;
                  default:           held_value = csr_prdata;
               endcase
               if (csr_prdata !== held_value) begin
                  $error("csr_prdata at 0x%0h: expected 0x%0h, actual 0x%0h",
                         csr_paddr, held_value, csr_prdata);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(classify_scan(req_tdata[0], req_tdata[NOW_BITS:1]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got_status = rsp_tdata[2:0];
            got_kind = rsp_tdata[4:3];
            got_hold = rsp_tdata[5 +: HOLD_BITS];
            if (expected_results.size() == 0) begin
               $error("rsp transfer with no scan result pending: status %0d", got_status);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (got_status !== want.status) begin
                  $error("scan_status: expected %0d, actual %0d", want.status, got_status);
                  mismatch_count++;
               end
               if (got_kind !== want.kind) begin
                  $error("released_kind: expected %0d, actual %0d", want.kind, got_kind);
                  mismatch_count++;
               end
               if (got_hold !== want.hold_ms) begin
                  $error("hold_duration_ms: expected %0d, actual %0d", want.hold_ms, got_hold);
                  mismatch_count++;
               end
            end
         end
      end
      results_waiting <= expected_results.size();
   end

endmodule

// ----- test/testbench.sv -----
// Top of the classifier testbench: clock, reset, register setup, scan stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import bphdc_pkg::*;

   localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [2:0] REG_SPARE_LAST  = 3'd7;
   localparam int HALF_PERIOD    = 10;
   localparam int PHASES         = 12;
   localparam int PHASE_SCANS    = 150;
   localparam int IDLE_PERCENT   = 11;
   localparam int NOISE_PERCENT  = 5;
   localparam int BOUNCE_PERCENT = 8;
   localparam int SETTLE_CYCLES  = 10;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_BYTES*8-1:0]     req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_BYTES*8-1:0]     rsp_tdata;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]   csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]   csr_prdata;
   logic                       csr_pready;
   logic                       steady = 1'b0;
   int                         mismatch_count;
   int                         results_waiting;

   button_press_hold_double_classifier uut (.*);

   button_scan_checker scan_check (.*);

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   task automatic send_scan(input logic pin, input time_type stamp);
      logic [REQ_BYTES*8-1:0] word;
      word = '0;
      word[0] = pin;
      word[NOW_BITS:1] = stamp;
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_for_results;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_waiting != 0) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [2:0] index,
                             input logic [CSR_DATA_BITS-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_registers;
      for (int i = REG_ACTIVE_HIGH; i <= REG_DOUBLE_WINDOW; i++) begin
         csr_access(1'b0, i[2:0], '0);
      end
   endtask

   // clear the debounce windows first so the clamps never bite on the hold and window targets
   task automatic load_settings(input logic active, input ms_type press_ms,
                                input ms_type release_ms, input ms_type hold_ms,
                                input ms_type window_ms);
      csr_access(1'b1, REG_PRESS_DEB, '0);
      csr_access(1'b1, REG_RELEASE_DEB, '0);
      csr_access(1'b1, REG_HOLD_THRESH, {16'($urandom), hold_ms});
      csr_access(1'b1, REG_DOUBLE_WINDOW, {16'($urandom), window_ms});
      csr_access(1'b1, REG_PRESS_DEB, {16'($urandom), press_ms});
      csr_access(1'b1, REG_RELEASE_DEB, {16'($urandom), release_ms});
      csr_access(1'b1, REG_ACTIVE_HIGH, {31'($urandom), active});
      read_registers();
   endtask

   initial begin : stimulus
      time_type scan_ms;
      logic     level;
      int       step;
      int       sent;
      ms_type   hold_ms;
      ms_type   window_ms;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // start-up debounce, double press off the reset stamp, hold, release kinds, wrap
      send_scan(1'b1, 32'd0);
      send_scan(1'b1, 32'd49);
      send_scan(1'b1, 32'd100);
      send_scan(1'b0, 32'd200);
      send_scan(1'b0, 32'd220);
      send_scan(1'b0, 32'd300);
      send_scan(1'b0, 32'd1200);
      send_scan(1'b0, 32'd1300);
      send_scan(1'b1, 32'd1400);
      send_scan(1'b1, 32'd1420);
      send_scan(1'b0, 32'd1500);
      send_scan(1'b1, 32'd1600);
      send_scan(1'b1, 32'd1700);
      send_scan(1'b0, 32'd2000);
      send_scan(1'b1, 32'd2100);
      send_scan(1'b0, 32'hFFFF_FFF0);
      send_scan(1'b0, 32'd1024);
      send_scan(1'b0, 32'hFFFF_FFFF);
      send_scan(1'b1, 32'h0000_0800);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_results();
         steady <= (phase == 0);
         case (phase)
            0: begin
               load_settings(1'b1, 16'd5, 16'd5, 16'd40, 16'd20);
               step = 12;
            end
            1: begin
               csr_access(1'b1, REG_PRESS_DEB, 32'hFFFF_FFFF);
               csr_access(1'b1, REG_RELEASE_DEB, 32'h0001_FFFF);
               csr_access(1'b1, REG_HOLD_THRESH, 32'hFFFF_0000);
               csr_access(1'b1, REG_DOUBLE_WINDOW, 32'h0000_0001);
               csr_access(1'b1, REG_ACTIVE_HIGH, 32'hFFFF_FFFE);
               csr_access(1'b1, REG_SPARE_FIRST, 32'h0000_0000);
               csr_access(1'b1, REG_SPARE_LAST, 32'hFFFF_FFFF);
               read_registers();
               step = 15;
            end
            2: begin
               load_settings(1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
               step = 3;
            end
            3: begin
               load_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
               step = 40000;
            end
            default: begin
               hold_ms = 16'($urandom_range(0, 1500));
               window_ms = 16'($urandom_range(0, 800));
               load_settings($urandom_range(0, 1) == 1, 16'($urandom_range(0, 120)),
                             16'($urandom_range(0, 120)), hold_ms, window_ms);
               step = (hold_ms + window_ms) / 4 + 2;
            end
         endcase

         if (phase % 4 == 1) begin
            scan_ms = ~time_type'($urandom_range(0, 4 * step));
         end else begin
            scan_ms = $urandom;
         end
         level = ($urandom_range(0, 1) == 1);
         sent = 0;
         while (sent < PHASE_SCANS) begin
            level = ~level;
            repeat ($urandom_range(1, 12)) begin
               if ($urandom_range(0, 99) < NOISE_PERCENT) begin
                  send_scan($urandom_range(0, 1) == 1, $urandom);
               end else begin
                  scan_ms = scan_ms + $urandom_range(0, step);
                  send_scan(($urandom_range(0, 99) < BOUNCE_PERCENT) ? ~level : level, scan_ms);
               end
               sent++;
            end
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("button_press_hold_double_classifier test passed");
      end else begin
         $display("button_press_hold_double_classifier test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("button_press_hold_double_classifier test failed");
      $finish;
   end

endmodule
